// ===== rtl/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Monomial power combiner package
// Shared types, widths and queue sizes for the combiner block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpc_pkg;

	// Largest number of slots in one row.
	localparam int MAX_COLS    = 256;
	localparam int SLOT_IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_SLOTS_W = 9;

	// Field widths.
	localparam int VAR_W  = 16;
	localparam int POW_W  = 16;
	localparam int TERM_W = 24;

	// Saturation limits of the summed power.
	localparam logic signed [TERM_W-1:0] TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
	localparam logic signed [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};

	// Input queue between front and back (depth is a power of two).
	localparam int IQ_DEPTH = 4;
	localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
	localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

	// Result queue (depth is a power of two, at least two).
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// One input transaction.
	typedef struct packed {
		logic [VAR_W-1:0]        variable;
		logic signed [POW_W-1:0] power;
		logic                    row_end;
		logic                    matrix_start;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [VAR_W-1:0]         term_variable;
		logic signed [TERM_W-1:0] term_power;
		logic                     last_of_row;
		logic [ROW_SLOTS_W-1:0]   row_slots;
		logic [ROW_SLOTS_W-1:0]   max_slots;
	} out_item_t;

	// An input item with its classification flags, as queued by the front.
	typedef struct packed {
		in_item_t item;
		logic     var_zero;
		logic     pow_zero;
	} cls_item_t;

	// Up to two results produced by the back for one item, oldest first.
	typedef struct packed {
		logic      valid0;
		logic      valid1;
		out_item_t res0;
		out_item_t res1;
	} res_pair_t;

endpackage

// ===== rtl/mpc_front.sv =====
// ----------------------------------------------------------------------------
// Monomial power combiner front end
// Accepts input transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mpc_pkg::in_item_t  item,
	output logic               head_valid,
	input  logic               take,
	output mpc_pkg::cls_item_t head
);

	localparam logic [mpc_pkg::IQ_CNT_W-1:0] IQ_FULL =
		mpc_pkg::IQ_CNT_W'(mpc_pkg::IQ_DEPTH);

	mpc_pkg::cls_item_t               mem_q [mpc_pkg::IQ_DEPTH];
	logic [mpc_pkg::IQ_PTR_W-1:0]     wr_ptr_q;
	logic [mpc_pkg::IQ_PTR_W-1:0]     rd_ptr_q;
	logic [mpc_pkg::IQ_CNT_W-1:0]     count_q;
	logic                             do_push;
	logic                             do_pop;
	mpc_pkg::cls_item_t               cls;

	assign full       = (count_q == IQ_FULL);
	assign head_valid = (count_q != '0);
	assign do_push    = push && !full;
	assign do_pop     = take && head_valid;
	assign head       = mem_q[rd_ptr_q];

	// Classify the entry on the way in.
	always_comb begin
		cls.item     = item;
		cls.var_zero = (item.variable == '0);
		cls.pow_zero = (item.power == '0);
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/mpc_back.sv =====
// ----------------------------------------------------------------------------
// Monomial power combiner back end
// Merges queued entries into the open slot and produces up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  mpc_pkg::cls_item_t head,
	input  logic               space,
	output logic               take,
	output mpc_pkg::res_pair_t res
);

	localparam logic [mpc_pkg::SLOT_IDX_W-1:0] SLOT_LAST =
		mpc_pkg::SLOT_IDX_W'(mpc_pkg::MAX_COLS - 1);

	logic                                list_ended_q;
	logic [mpc_pkg::VAR_W-1:0]           slot_var_q;
	logic signed [mpc_pkg::TERM_W-1:0]   slot_pow_q;
	logic [mpc_pkg::SLOT_IDX_W-1:0]      slot_idx_q;
	logic [mpc_pkg::SLOT_IDX_W-1:0]      max_idx_q;

	logic                                le_cur;
	logic [mpc_pkg::VAR_W-1:0]           sv_cur;
	logic signed [mpc_pkg::TERM_W-1:0]   sp_cur;
	logic [mpc_pkg::SLOT_IDX_W-1:0]      si_cur;
	logic [mpc_pkg::SLOT_IDX_W-1:0]      mi_cur;

	logic                                le_nxt;
	logic [mpc_pkg::VAR_W-1:0]           sv_nxt;
	logic signed [mpc_pkg::TERM_W-1:0]   sp_nxt;
	logic [mpc_pkg::SLOT_IDX_W-1:0]      si_nxt;
	logic [mpc_pkg::SLOT_IDX_W-1:0]      mi_nxt;

	logic signed [mpc_pkg::TERM_W:0]     sum_wide;
	logic signed [mpc_pkg::TERM_W-1:0]   sum_sat;
	logic                                emit_close;

	assign take = head_valid && space;

	// Matrix start clears the row and the running maximum first.
	always_comb begin
		le_cur = head.item.matrix_start ? 1'b0 : list_ended_q;
		sv_cur = head.item.matrix_start ? '0 : slot_var_q;
		sp_cur = head.item.matrix_start ? '0 : slot_pow_q;
		si_cur = head.item.matrix_start ? '0 : slot_idx_q;
		mi_cur = head.item.matrix_start ? '0 : max_idx_q;
	end

	// Saturating sum of the slot power and the entry power.
	always_comb begin
		sum_wide = {sp_cur[mpc_pkg::TERM_W-1], sp_cur}
			+ (mpc_pkg::TERM_W + 1)'(head.item.power);
		if (sum_wide[mpc_pkg::TERM_W] != sum_wide[mpc_pkg::TERM_W-1]) begin
			sum_sat = sum_wide[mpc_pkg::TERM_W] ? mpc_pkg::TERM_MIN : mpc_pkg::TERM_MAX;
		end else begin
			sum_sat = sum_wide[mpc_pkg::TERM_W-1:0];
		end
	end

	// Slot update and result formation.
	always_comb begin
		le_nxt     = le_cur;
		sv_nxt     = sv_cur;
		sp_nxt     = sp_cur;
		si_nxt     = si_cur;
		mi_nxt     = mi_cur;
		emit_close = 1'b0;

		if (!le_cur) begin
			if (head.var_zero) begin
				le_nxt = 1'b1;
			end else if (!head.pow_zero) begin
				if (sv_cur == '0) begin
					sv_nxt = head.item.variable;
					sp_nxt = mpc_pkg::TERM_W'(head.item.power);
				end else if (sv_cur == head.item.variable) begin
					sp_nxt = sum_sat;
					if (sum_sat == '0) begin
						sv_nxt = '0;
					end
				end else begin
					emit_close = 1'b1;
					if (si_cur != SLOT_LAST) begin
						si_nxt = si_cur + 1'b1;
					end
					sv_nxt = head.item.variable;
					sp_nxt = mpc_pkg::TERM_W'(head.item.power);
				end
			end
		end

		if (head.item.row_end && (si_nxt > mi_cur)) begin
			mi_nxt = si_nxt;
		end

		res.valid0             = take && emit_close;
		res.res0.term_variable = sv_cur;
		res.res0.term_power    = sp_cur;
		res.res0.last_of_row   = 1'b0;
		res.res0.row_slots     = '0;
		res.res0.max_slots     = '0;

		res.valid1             = take && head.item.row_end;
		res.res1.term_variable = sv_nxt;
		res.res1.term_power    = sp_nxt;
		res.res1.last_of_row   = 1'b1;
		res.res1.row_slots     = mpc_pkg::ROW_SLOTS_W'(si_nxt) + mpc_pkg::ROW_SLOTS_W'(1);
		res.res1.max_slots     = mpc_pkg::ROW_SLOTS_W'(mi_nxt) + mpc_pkg::ROW_SLOTS_W'(1);
	end

	// Row and matrix state; a row end returns the row to its cleared state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_ended_q <= 1'b0;
			slot_var_q   <= '0;
			slot_pow_q   <= '0;
			slot_idx_q   <= '0;
			max_idx_q    <= '0;
		end else if (take) begin
			max_idx_q <= mi_nxt;
			if (head.item.row_end) begin
				list_ended_q <= 1'b0;
				slot_var_q   <= '0;
				slot_pow_q   <= '0;
				slot_idx_q   <= '0;
			end else begin
				list_ended_q <= le_nxt;
				slot_var_q   <= sv_nxt;
				slot_pow_q   <= sp_nxt;
				slot_idx_q   <= si_nxt;
			end
		end
	end

endmodule

// ===== rtl/mpc_out_queue.sv =====
// ----------------------------------------------------------------------------
// Monomial power combiner result queue
// Takes up to two results per cycle in order and hands them out one at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpc_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  mpc_pkg::res_pair_t res,
	output logic               space,
	output logic               empty,
	input  logic               pop,
	output mpc_pkg::out_item_t result
);

	localparam logic [mpc_pkg::OQ_CNT_W-1:0] OQ_ROOM =
		mpc_pkg::OQ_CNT_W'(mpc_pkg::OQ_DEPTH - 2);

	mpc_pkg::out_item_t               mem_q [mpc_pkg::OQ_DEPTH];
	logic [mpc_pkg::OQ_PTR_W-1:0]     wr_ptr_q;
	logic [mpc_pkg::OQ_PTR_W-1:0]     rd_ptr_q;
	logic [mpc_pkg::OQ_CNT_W-1:0]     count_q;
	logic [mpc_pkg::OQ_PTR_W-1:0]     wr_ptr_p1;
	logic                             any_push;
	logic                             two_push;
	logic                             do_pop;
	logic [mpc_pkg::OQ_CNT_W-1:0]     n_push;
	mpc_pkg::out_item_t               first;

	assign space     = (count_q <= OQ_ROOM);
	assign empty     = (count_q == '0);
	assign do_pop    = pop && !empty;
	assign result    = mem_q[rd_ptr_q];
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign any_push  = res.valid0 || res.valid1;
	assign two_push  = res.valid0 && res.valid1;
	assign first     = res.valid0 ? res.res0 : res.res1;
	assign n_push    = two_push ? mpc_pkg::OQ_CNT_W'(2)
		: (any_push ? mpc_pkg::OQ_CNT_W'(1) : '0);

	// Storage: the older result goes to the write pointer.
	always_ff @(posedge clk) begin
		if (any_push) begin
			mem_q[wr_ptr_q] <= first;
		end
		if (two_push) begin
			mem_q[wr_ptr_p1] <= res.res1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + mpc_pkg::OQ_PTR_W'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + n_push - mpc_pkg::OQ_CNT_W'(do_pop);
		end
	end

endmodule

// ===== rtl/monomial_power_combiner_unit.sv =====
// ----------------------------------------------------------------------------
// Monomial power combiner
// Combines the (variable, power) entries of monomial rows into terms.
// ----------------------------------------------------------------------------
// Path: an accepted item is written to the input queue, combined by the back end,
// and its results are registered in the result queue, which drives the result ports.
// Throughput: one item per cycle; an item may yield two results, and the back
// end waits while the result queue has room for fewer than two.
// Reset: arst_n clears the queues and all row and matrix state at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module monomial_power_combiner_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mpc_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output mpc_pkg::out_item_t result
);

	logic               head_valid;
	logic               take;
	logic               space;
	mpc_pkg::cls_item_t head;
	mpc_pkg::res_pair_t res;

	// Front end: accept and classify.
	mpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.head_valid (head_valid),
		.take       (take),
		.head       (head)
	);

	// Back end: combine powers into slots.
	mpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.space      (space),
		.take       (take),
		.res        (res)
	);

	// Result queue.
	mpc_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.space  (space),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// The back end only takes an item when the result queue can hold two results.
	a_take_space: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (space && head_valid))
		else $error("item taken without room in the result queue");

	// A row end always leaves a result waiting in the next cycle.
	a_row_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.item.row_end) |=> !empty)
		else $error("row end produced no result");

	// The closing result of a row carries a nonzero slot count.
	a_final_count: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid1 |-> (res.res1.last_of_row && (res.res1.row_slots != '0)
			&& (res.res1.max_slots >= res.res1.row_slots)))
		else $error("bad slot counts on final result");

endmodule
